@@ rtl/assert_macros.svh @@
// assertion macros for the rtl files, included by the top level
// no dependencies; each macro expects clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rpv_pkg.sv @@
// types and constants of the ripng packet validator
// no dependencies; used by all rtl modules
`default_nettype none

package rpv_pkg;

  // byte positions inside the packet
  localparam int unsigned POS_W = 17;
  localparam logic [POS_W-1:0] POS_MAX         = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] POS_PLEN_HI     = 17'd4;
  localparam logic [POS_W-1:0] POS_PLEN_LO     = 17'd5;
  localparam logic [POS_W-1:0] POS_NEXT_HDR    = 17'd6;
  localparam logic [POS_W-1:0] POS_SPORT_HI    = 17'd40;
  localparam logic [POS_W-1:0] POS_SPORT_LO    = 17'd41;
  localparam logic [POS_W-1:0] POS_DPORT_HI    = 17'd42;
  localparam logic [POS_W-1:0] POS_DPORT_LO    = 17'd43;
  localparam logic [POS_W-1:0] POS_ULEN_HI     = 17'd44;
  localparam logic [POS_W-1:0] POS_ULEN_LO     = 17'd45;
  localparam logic [POS_W-1:0] POS_COMMAND     = 17'd48;
  localparam logic [POS_W-1:0] POS_VERSION     = 17'd49;
  localparam logic [POS_W-1:0] POS_ZERO_HI     = 17'd50;
  localparam logic [POS_W-1:0] POS_ZERO_LO     = 17'd51;
  localparam logic [POS_W-1:0] ENTRY_START     = 17'd52;
  localparam logic [POS_W:0]   IPV6_HDR_LEN    = 18'd40;

  // byte index inside one 20-byte route entry
  localparam logic [4:0] IDX_PFX_LO_START = 5'd8;
  localparam logic [4:0] IDX_TAG_HI       = 5'd16;
  localparam logic [4:0] IDX_TAG_LO       = 5'd17;
  localparam logic [4:0] IDX_PLEN         = 5'd18;
  localparam logic [4:0] IDX_METRIC       = 5'd19;

  localparam logic [7:0]  UDP_PROTO       = 8'd17;
  localparam logic [15:0] RIPNG_PORT      = 16'd521;
  localparam logic [7:0]  RIPNG_VERSION   = 8'd1;
  localparam logic [7:0]  CMD_REQUEST     = 8'd1;
  localparam logic [7:0]  CMD_RESPONSE    = 8'd2;
  localparam logic [7:0]  NEXT_HOP_METRIC = 8'hff;
  localparam logic [7:0]  MIN_METRIC      = 8'd1;
  localparam logic [7:0]  MAX_METRIC      = 8'd16;
  localparam logic [7:0]  MAX_PREFIX_LEN  = 8'd128;
  localparam logic [11:0] ENTRIES_MAX     = 12'hfff;

  // header error flag bits
  localparam int unsigned FLAG_NOT_UDP = 0;
  localparam int unsigned FLAG_PORT    = 1;
  localparam int unsigned FLAG_VERSION = 2;
  localparam int unsigned FLAG_ZERO    = 3;

  localparam logic RES_ENTRY  = 1'b0;
  localparam logic RES_STATUS = 1'b1;

  // result queue, depth must be a power of two
  localparam int unsigned RES_DEPTH = 8;
  localparam int unsigned PTR_W     = $clog2(RES_DEPTH);
  localparam int unsigned CNT_W     = $clog2(RES_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_OK,
    ST_LENGTH,
    ST_NOT_UDP,
    ST_PORT,
    ST_COMMAND,
    ST_VERSION,
    ST_ZERO,
    ST_PREFIX_LEN,
    ST_TAG,
    ST_METRIC,
    ST_PREFIX_BITS
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] prefix_high;
    logic [63:0] prefix_low;
    logic [15:0] tag_bytes;
    logic [7:0]  entry_prefix_length;
    logic [7:0]  entry_metric;
    logic [3:0]  status;
    logic [7:0]  command_out;
    logic [11:0] entry_total;
  } out_item_t;

  // up to two results per byte, the entry goes ahead of the status
  typedef struct packed {
    logic      entry_valid;
    logic      status_valid;
    out_item_t entry;
    out_item_t stat;
  } push_t;

endpackage

`default_nettype wire

@@ rtl/rpv_parser.sv @@
// per-byte packet parser: header checks, route entry gathering and checks
// depends on rpv_pkg
`default_nettype none

module rpv_parser import rpv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     act,
  input  in_item_t item,
  output push_t    push
);

  logic [POS_W-1:0] pos, pos_next;
  logic [15:0]      pay_len, pay_len_next;
  logic [15:0]      udp_len, udp_len_next;
  logic [3:0]       flags, flags_next;
  logic [7:0]       cmd, cmd_next;
  logic [4:0]       idx, idx_next;
  logic [63:0]      pfx_hi, pfx_hi_next;
  logic [63:0]      pfx_lo, pfx_lo_next;
  logic [15:0]      tag, tag_next;
  logic [7:0]       plen, plen_next;
  status_t          ent_err, ent_err_next;
  logic [11:0]      ent_cnt, ent_cnt_next;

  logic [7:0]       b;
  logic [POS_W:0]   len;
  status_t          entry_st;
  status_t          pkt_st;

  assign b   = item.data_byte;
  assign len = {1'b0, pos} + (POS_W+1)'(1);

  function automatic status_t entry_check(input logic [7:0] metric,
                                          input logic [7:0] pl,
                                          input logic [15:0] tg,
                                          input logic [63:0] hi,
                                          input logic [63:0] lo);
    logic [127:0] rest;
    status_t      res;
    rest = {hi, lo} << pl;
    if (metric == NEXT_HOP_METRIC) begin
      if (pl != 8'd0) res = ST_PREFIX_LEN;
      else if (tg != 16'd0) res = ST_TAG;
      else res = ST_OK;
    end else if (metric < MIN_METRIC || metric > MAX_METRIC) begin
      res = ST_METRIC;
    end else if (pl > MAX_PREFIX_LEN) begin
      res = ST_PREFIX_LEN;
    end else if (rest != 128'd0) begin
      // a set bit survives the shift only if it lies past the prefix length
      res = ST_PREFIX_BITS;
    end else begin
      res = ST_OK;
    end
    return res;
  endfunction

  always_comb begin
    pos_next     = pos;
    pay_len_next = pay_len;
    udp_len_next = udp_len;
    flags_next   = flags;
    cmd_next     = cmd;
    idx_next     = idx;
    pfx_hi_next  = pfx_hi;
    pfx_lo_next  = pfx_lo;
    tag_next     = tag;
    plen_next    = plen;
    ent_err_next = ent_err;
    ent_cnt_next = ent_cnt;
    entry_st     = ST_OK;
    pkt_st       = ST_OK;
    push         = '0;

    if (act) begin
      unique case (pos)
        POS_PLEN_HI:  pay_len_next = {b, pay_len[7:0]};
        POS_PLEN_LO:  pay_len_next = {pay_len[15:8], b};
        POS_NEXT_HDR: if (b != UDP_PROTO) flags_next[FLAG_NOT_UDP] = 1'b1;
        POS_SPORT_HI, POS_DPORT_HI: begin
          if (b != RIPNG_PORT[15:8]) flags_next[FLAG_PORT] = 1'b1;
        end
        POS_SPORT_LO, POS_DPORT_LO: begin
          if (b != RIPNG_PORT[7:0]) flags_next[FLAG_PORT] = 1'b1;
        end
        POS_ULEN_HI:  udp_len_next = {b, udp_len[7:0]};
        POS_ULEN_LO:  udp_len_next = {udp_len[15:8], b};
        POS_COMMAND:  cmd_next = b;
        POS_VERSION:  if (b != RIPNG_VERSION) flags_next[FLAG_VERSION] = 1'b1;
        POS_ZERO_HI, POS_ZERO_LO: begin
          if (b != 8'd0) flags_next[FLAG_ZERO] = 1'b1;
        end
        default: ;
      endcase

      if (pos >= ENTRY_START && pos != POS_MAX) begin
        if (idx < IDX_PFX_LO_START) pfx_hi_next = {pfx_hi[55:0], b};
        else if (idx < IDX_TAG_HI) pfx_lo_next = {pfx_lo[55:0], b};
        else if (idx == IDX_TAG_HI) tag_next = {b, tag[7:0]};
        else if (idx == IDX_TAG_LO) tag_next = {tag[15:8], b};
        else if (idx == IDX_PLEN) plen_next = b;

        if (idx >= IDX_METRIC) begin
          idx_next = 5'd0;
          if (ent_cnt != ENTRIES_MAX) ent_cnt_next = ent_cnt + 12'd1;
          if (ent_err == ST_OK) begin
            entry_st = entry_check(b, plen, tag, pfx_hi, pfx_lo);
            if (entry_st != ST_OK) begin
              ent_err_next = entry_st;
            end else begin
              push.entry_valid               = 1'b1;
              push.entry.kind                = RES_ENTRY;
              push.entry.prefix_high         = pfx_hi;
              push.entry.prefix_low          = pfx_lo;
              push.entry.tag_bytes           = tag;
              push.entry.entry_prefix_length = plen;
              push.entry.entry_metric        = b;
            end
          end
        end else begin
          idx_next = idx + 5'd1;
        end
      end

      if (item.last_byte) begin
        // a payload of 12 plus whole entries leaves the entry index at zero
        priority if (len < {1'b0, ENTRY_START} ||
                     len != {2'b00, pay_len_next} + IPV6_HDR_LEN) begin
          pkt_st = ST_LENGTH;
        end else if (flags_next[FLAG_NOT_UDP]) begin
          pkt_st = ST_NOT_UDP;
        end else if (udp_len_next != pay_len_next) begin
          pkt_st = ST_LENGTH;
        end else if (flags_next[FLAG_PORT]) begin
          pkt_st = ST_PORT;
        end else if (idx_next != 5'd0) begin
          pkt_st = ST_LENGTH;
        end else if (cmd_next != CMD_REQUEST && cmd_next != CMD_RESPONSE) begin
          pkt_st = ST_COMMAND;
        end else if (flags_next[FLAG_VERSION]) begin
          pkt_st = ST_VERSION;
        end else if (flags_next[FLAG_ZERO]) begin
          pkt_st = ST_ZERO;
        end else begin
          pkt_st = ent_err_next;
        end

        push.status_valid = 1'b1;
        push.stat.kind    = RES_STATUS;
        push.stat.status  = pkt_st;
        if (pkt_st == ST_OK || pkt_st >= ST_PREFIX_LEN) begin
          push.stat.command_out = cmd_next;
          push.stat.entry_total = ent_cnt_next;
        end

        pos_next     = '0;
        pay_len_next = '0;
        udp_len_next = '0;
        flags_next   = '0;
        cmd_next     = '0;
        idx_next     = '0;
        ent_err_next = ST_OK;
        ent_cnt_next = '0;
      end else if (pos != POS_MAX) begin
        pos_next = pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      pay_len <= '0;
      udp_len <= '0;
      flags   <= '0;
      cmd     <= '0;
      idx     <= '0;
      ent_err <= ST_OK;
      ent_cnt <= '0;
    end else begin
      pos     <= pos_next;
      pay_len <= pay_len_next;
      udp_len <= udp_len_next;
      flags   <= flags_next;
      cmd     <= cmd_next;
      idx     <= idx_next;
      ent_err <= ent_err_next;
      ent_cnt <= ent_cnt_next;
    end
    pfx_hi <= pfx_hi_next;
    pfx_lo <= pfx_lo_next;
    tag    <= tag_next;
    plen   <= plen_next;
  end

endmodule

`default_nettype wire

@@ rtl/rpv_result_fifo.sv @@
// result queue: takes up to two results per cycle, hands out one per cycle while result_ready is high
// depends on rpv_pkg
`default_nettype none

module rpv_result_fifo import rpv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  push_t            push,
  input  logic             result_ready,
  output logic             result_valid,
  output out_item_t        result,
  output logic [CNT_W-1:0] fill
);

  out_item_t        slots [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] wr_ptr_p1;
  logic [PTR_W-1:0] rd_ptr;
  logic [1:0]       n_push;
  logic             pop;

  assign n_push       = {1'b0, push.entry_valid} + {1'b0, push.status_valid};
  assign wr_ptr_p1    = wr_ptr + PTR_W'(1);
  assign result_valid = fill != '0;
  assign result       = slots[rd_ptr];
  assign pop          = result_valid & result_ready;

  always_ff @(posedge clk) begin
    if (push.entry_valid) begin
      slots[wr_ptr] <= push.entry;
      if (push.status_valid) slots[wr_ptr_p1] <= push.stat;
    end else if (push.status_valid) begin
      slots[wr_ptr] <= push.stat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      fill   <= fill + CNT_W'(n_push) - CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

@@ rtl/ripng_packet_validator.sv @@
// top level of the ripng packet validator: input register, parser, result queue
// depends on rpv_pkg, rpv_parser, rpv_result_fifo and assert_macros.svh
//
// usage:
//   item channel (item_valid/item_ready/item) carries one packet byte per item,
//   starting at the first ipv6 header byte, last_byte set on the final byte.
//   result channel (result_valid/result_ready/result) carries a route entry
//   result (kind 0) for each good 20-byte entry up to the first bad one, and
//   one status result (kind 1) on the final byte, after that byte's entry.
//   throughput: one byte per cycle while item_ready is high; the byte register
//   feeds the parser, which pushes up to two results into an eight-deep queue.
//   an accepted byte is registered, and its results are then queued in order.
//   item_ready drops only when the queue could not take the results of the
//   byte in the register plus one more; with the receiver stalled this
//   happens after a few results have piled up, and nothing is lost.
//   reset clears the byte count, header fields, entry count and the queue.
`default_nettype none
`include "assert_macros.svh"

module ripng_packet_validator import rpv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  logic             stage_valid;
  in_item_t         stage_item;
  push_t            push;
  logic [CNT_W-1:0] fill;
  logic [CNT_W:0]   need;

  // room for the byte in the register and for the new one, two results each
  assign need       = {1'b0, fill} + (stage_valid ? (CNT_W+1)'(4) : (CNT_W+1)'(2));
  assign item_ready = need <= (CNT_W+1)'(RES_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= item_valid & item_ready;
    end
    if (item_valid & item_ready) stage_item <= item;
  end

  rpv_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .act  (stage_valid),
    .item (stage_item),
    .push (push)
  );

  rpv_result_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result),
    .fill         (fill)
  );

  `ASSERT_SAME(a_fill_bound, 1'b1, fill <= CNT_W'(RES_DEPTH), "result queue overflow")
  `ASSERT_NEXT(a_stage_load, item_valid && item_ready, stage_valid, "accepted byte not registered")
  `ASSERT_NEXT(a_status_out, stage_valid && stage_item.last_byte, result_valid, "no status result")
  `ASSERT_SAME(a_two_push, push.entry_valid && push.status_valid, stage_item.last_byte,
               "double push without final byte")

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// testbench for the ripng packet validator: feeds whole packets one byte per item
// and checks every route entry and status result against a local prediction
// depends on rpv_pkg and ripng_packet_validator
`timescale 1ns / 100ps

module testbench;
  import rpv_pkg::*;

  localparam logic [7:0]  NH_TCP       = 8'd6;
  localparam logic [7:0]  CMD_NONE     = 8'd0;
  localparam logic [7:0]  CMD_UNKNOWN  = 8'hff;
  localparam logic [15:0] PORT_RIP_V4  = 16'd520;
  localparam int          RANDOM_BYTES = 400;

  class route_scoreboard;
    logic [16:0] pos;
    logic [15:0] pay_len;
    logic [15:0] udp_len;
    logic [3:0]  hdr_flags;
    logic [7:0]  cmd;
    logic [4:0]  ent_idx;
    logic [63:0] pfx_hi;
    logic [63:0] pfx_lo;
    logic [15:0] tag;
    logic [7:0]  pfx_len;
    status_t     first_err;
    logic [11:0] n_entries;
    out_item_t   pending[$];
    int          errors;
    int          n_checked;
    int          entries_out;
    int          packets_out;
    int          most_entries;
    int          status_seen[11];

    function new();
      clear();
    endfunction

    function void clear();
      pos = '0;
      pay_len = '0;
      udp_len = '0;
      hdr_flags = '0;
      cmd = '0;
      ent_idx = '0;
      pfx_hi = '0;
      pfx_lo = '0;
      tag = '0;
      pfx_len = '0;
      first_err = ST_OK;
      n_entries = '0;
    endfunction

    function status_t entry_verdict(logic [7:0] metric);
      logic [127:0] host;
      if (metric == NEXT_HOP_METRIC) begin
        if (pfx_len != 0) return ST_PREFIX_LEN;
        if (tag != 0) return ST_TAG;
        return ST_OK;
      end
      if (metric < MIN_METRIC || metric > MAX_METRIC) return ST_METRIC;
      if (pfx_len > MAX_PREFIX_LEN) return ST_PREFIX_LEN;
      host = {128{1'b1}} >> pfx_len;
      if (({pfx_hi, pfx_lo} & host) != 0) return ST_PREFIX_BITS;
      return ST_OK;
    endfunction

    function void note_byte(in_item_t it);
      logic [7:0] b;
      int         len;
      status_t    st;
      status_t    verdict;
      out_item_t  o;
      b = it.data_byte;
      case (pos)
        POS_PLEN_HI: pay_len[15:8] = b;
        POS_PLEN_LO: pay_len[7:0] = b;
        POS_NEXT_HDR: if (b != UDP_PROTO) hdr_flags[FLAG_NOT_UDP] = 1'b1;
        POS_SPORT_HI, POS_DPORT_HI: if (b != RIPNG_PORT[15:8]) hdr_flags[FLAG_PORT] = 1'b1;
        POS_SPORT_LO, POS_DPORT_LO: if (b != RIPNG_PORT[7:0]) hdr_flags[FLAG_PORT] = 1'b1;
        POS_ULEN_HI: udp_len[15:8] = b;
        POS_ULEN_LO: udp_len[7:0] = b;
        POS_COMMAND: cmd = b;
        POS_VERSION: if (b != RIPNG_VERSION) hdr_flags[FLAG_VERSION] = 1'b1;
        POS_ZERO_HI, POS_ZERO_LO: if (b != 0) hdr_flags[FLAG_ZERO] = 1'b1;
        default: ;
      endcase

      // route entries are gathered until the byte count saturates
      if (pos >= ENTRY_START && pos != POS_MAX) begin
        if (ent_idx < IDX_PFX_LO_START) pfx_hi = {pfx_hi[55:0], b};
        else if (ent_idx < IDX_TAG_HI) pfx_lo = {pfx_lo[55:0], b};
        else if (ent_idx == IDX_TAG_HI) tag[15:8] = b;
        else if (ent_idx == IDX_TAG_LO) tag[7:0] = b;
        else if (ent_idx == IDX_PLEN) pfx_len = b;
        if (ent_idx >= IDX_METRIC) begin
          ent_idx = '0;
          if (n_entries != ENTRIES_MAX) n_entries++;
          if (first_err == ST_OK) begin
            verdict = entry_verdict(b);
            if (verdict != ST_OK) begin
              first_err = verdict;
            end else begin
              o = '0;
              o.kind = RES_ENTRY;
              o.prefix_high = pfx_hi;
              o.prefix_low = pfx_lo;
              o.tag_bytes = tag;
              o.entry_prefix_length = pfx_len;
              o.entry_metric = b;
              pending.push_back(o);
            end
          end
        end else begin
          ent_idx++;
        end
      end

      if (it.last_byte) begin
        len = int'(pos) + 1;
        if (len < int'(ENTRY_START) || len != int'(IPV6_HDR_LEN) + int'(pay_len))
          st = ST_LENGTH;
        else if (hdr_flags[FLAG_NOT_UDP]) st = ST_NOT_UDP;
        else if (udp_len != pay_len) st = ST_LENGTH;
        else if (hdr_flags[FLAG_PORT]) st = ST_PORT;
        else if ((int'(pay_len) - 12) % 20 != 0) st = ST_LENGTH;
        else if (cmd != CMD_REQUEST && cmd != CMD_RESPONSE) st = ST_COMMAND;
        else if (hdr_flags[FLAG_VERSION]) st = ST_VERSION;
        else if (hdr_flags[FLAG_ZERO]) st = ST_ZERO;
        else st = first_err;
        o = '0;
        o.kind = RES_STATUS;
        o.status = st;
        // header errors hide the command and the count
        if (st == ST_OK || st >= ST_PREFIX_LEN) begin
          o.command_out = cmd;
          o.entry_total = n_entries;
        end
        pending.push_back(o);
        status_seen[st]++;
        clear();
      end else if (pos != POS_MAX) begin
        pos++;
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= 50) $display("mismatch: %s", what);
    endtask

    task cmp(string field, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %0h, want %0h", n_checked, field, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      n_checked++;
      if (pending.size() == 0) begin
        report($sformatf("result %0d (kind %0d, status %0d) with nothing expected",
                         n_checked, got.kind, got.status));
        return;
      end
      want = pending.pop_front();
      cmp("kind", got.kind, want.kind);
      cmp("prefix_high", got.prefix_high, want.prefix_high);
      cmp("prefix_low", got.prefix_low, want.prefix_low);
      cmp("tag_bytes", got.tag_bytes, want.tag_bytes);
      cmp("entry_prefix_length", got.entry_prefix_length, want.entry_prefix_length);
      cmp("entry_metric", got.entry_metric, want.entry_metric);
      cmp("status", got.status, want.status);
      cmp("command_out", got.command_out, want.command_out);
      cmp("entry_total", got.entry_total, want.entry_total);
      if (want.kind == RES_ENTRY) begin
        entries_out++;
      end else begin
        packets_out++;
        if (int'(want.entry_total) > most_entries) most_entries = int'(want.entry_total);
      end
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_item_t result;

  route_scoreboard sb = new();
  logic [7:0] pkt[$];
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold = 0;
  int quiet = 0;
  int bytes_sent = 0;

  ripng_packet_validator uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", sb.pending.size());
    $display("testbench: done, errors");
    $finish;
  end

  // receiver stalls in short bursts
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      result_ready <= 1'b0;
    end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
      rx_hold = $urandom_range(0, 3);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid === 1'b1 && item_ready === 1'b1) sb.note_byte(item);
      if (result_valid === 1'b1 && result_ready === 1'b1) sb.check_result(result);
    end
  end

  function automatic void put_header(logic [15:0] pl, logic [7:0] nh, logic [15:0] sp,
                                     logic [15:0] dp, logic [15:0] ul, logic [7:0] cmd,
                                     logic [7:0] ver, logic [15:0] zf);
    pkt.delete();
    pkt.push_back(8'h60);
    repeat (3) pkt.push_back(8'($urandom));
    pkt.push_back(pl[15:8]);
    pkt.push_back(pl[7:0]);
    pkt.push_back(nh);
    pkt.push_back(8'hff);
    repeat (32) pkt.push_back(8'($urandom));
    pkt.push_back(sp[15:8]);
    pkt.push_back(sp[7:0]);
    pkt.push_back(dp[15:8]);
    pkt.push_back(dp[7:0]);
    pkt.push_back(ul[15:8]);
    pkt.push_back(ul[7:0]);
    repeat (2) pkt.push_back(8'($urandom));  // udp checksum is not looked at
    pkt.push_back(cmd);
    pkt.push_back(ver);
    pkt.push_back(zf[15:8]);
    pkt.push_back(zf[7:0]);
  endfunction

  function automatic void good_header(logic [15:0] pl, logic [7:0] cmd);
    put_header(pl, UDP_PROTO, RIPNG_PORT, RIPNG_PORT, pl, cmd, RIPNG_VERSION, 16'h0);
  endfunction

  function automatic void add_entry(logic [127:0] pfx, logic [15:0] tag, logic [7:0] plen,
                                    logic [7:0] metric);
    for (int i = 15; i >= 0; i--) pkt.push_back(pfx[i*8 +: 8]);
    pkt.push_back(tag[15:8]);
    pkt.push_back(tag[7:0]);
    pkt.push_back(plen);
    pkt.push_back(metric);
  endfunction

  function automatic void add_rand_entry(bit bad);
    logic [127:0] pfx;
    logic [127:0] host;
    logic [15:0]  tag;
    logic [7:0]   plen;
    logic [7:0]   metric;
    bit           stray;
    pfx = {$urandom, $urandom, $urandom, $urandom};
    tag = 16'($urandom);
    plen = 8'($urandom_range(0, 128));
    metric = 8'($urandom_range(1, 16));
    stray = 1'b0;
    if ($urandom_range(3) == 0) begin
      metric = NEXT_HOP_METRIC;
      plen = '0;
      tag = '0;
    end
    if (bad) begin
      case ($urandom_range(3))
        0: metric = $urandom_range(1) ? 8'd0 : 8'($urandom_range(17, 254));
        1: plen = 8'($urandom_range(129, 255));
        2: begin
          metric = NEXT_HOP_METRIC;
          plen = '0;
          tag = 16'($urandom_range(1, 65535));
        end
        default: begin
          if (metric == NEXT_HOP_METRIC) metric = MAX_METRIC;
          plen = 8'($urandom_range(0, 127));
          stray = 1'b1;
        end
      endcase
    end
    host = {128{1'b1}} >> plen;
    if (metric != NEXT_HOP_METRIC) pfx = pfx & ~host;
    if (stray) pfx[$urandom_range(0, 127 - int'(plen))] = 1'b1;
    add_entry(pfx, tag, plen, metric);
  endfunction

  // mostly well-formed packets, some with one damaged header field, some cut or padded,
  // and some plain noise
  function automatic void rand_packet();
    int          mode;
    int          n_ent;
    int          extra;
    logic [15:0] pl;
    logic [15:0] ul;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [15:0] zf;
    logic [7:0]  nh;
    logic [7:0]  cmd;
    logic [7:0]  ver;
    mode = $urandom_range(99);
    n_ent = $urandom_range(0, 4);
    extra = 0;
    pl = 16'(12 + 20 * n_ent);
    ul = pl;
    nh = UDP_PROTO;
    sp = RIPNG_PORT;
    dp = RIPNG_PORT;
    cmd = $urandom_range(1) ? CMD_RESPONSE : CMD_REQUEST;
    ver = RIPNG_VERSION;
    zf = '0;
    if (mode >= 60 && mode < 80) begin
      case ($urandom_range(7))
        0: nh = 8'($urandom);
        1: sp = 16'($urandom);
        2: dp = 16'($urandom);
        3: ul = 16'($urandom);
        4: cmd = 8'($urandom);
        5: ver = 8'($urandom);
        6: zf = 16'($urandom);
        default: begin
          extra = $urandom_range(1, 19);
          pl = pl + 16'(extra);
          ul = pl;
        end
      endcase
    end
    put_header(pl, nh, sp, dp, ul, cmd, ver, zf);
    repeat (n_ent) add_rand_entry($urandom_range(9) == 0);
    repeat (extra) pkt.push_back(8'($urandom));
    if (mode >= 80 && mode < 90) begin
      if ($urandom_range(1) == 1)
        repeat ($urandom_range(1, pkt.size() - 1)) void'(pkt.pop_back());
      else
        repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom));
    end else if (mode >= 90) begin
      pkt.delete();
      repeat ($urandom_range(1, 120)) pkt.push_back(8'($urandom));
    end
  endfunction

  function automatic int pick_idle();
    case ($urandom_range(2))
      0: return 0;
      1: return 12;
      default: return 35;
    endcase
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{data_byte: b, last_byte: last};
    do @(posedge clk); while (item_ready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic send_packet();
    if (quiet != 0) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end else begin
      tx_idle_pct = pick_idle();
      rx_idle_pct = pick_idle();
    end
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // hold the sender off until every outstanding result has been seen
  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  initial begin
    int rand_from;
    int codes;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // well-formed response with a route and a next hop
    good_header(16'd52, CMD_RESPONSE);
    add_entry(128'h2001_0db8_0000_0000_0000_0000_0000_0000, 16'h1234, 8'd32, 8'd1);
    add_entry(128'hfe80_0000_0000_0000_0000_0000_0000_0001, 16'h0, 8'd0, NEXT_HOP_METRIC);
    send_packet();
    // bare request, then a full-table request
    good_header(16'd12, CMD_REQUEST);
    send_packet();
    good_header(16'd32, CMD_REQUEST);
    add_entry(128'h0, 16'h0, 8'd0, MAX_METRIC);
    send_packet();
    // prefix length extremes
    good_header(16'd72, CMD_RESPONSE);
    add_entry({128{1'b1}}, 16'hffff, MAX_PREFIX_LEN, MAX_METRIC);
    add_entry(128'h0, 16'h0, 8'd0, MIN_METRIC);
    add_entry(128'hffff_ffff_ffff_ffff_0000_0000_0000_0000, 16'h8001, 8'd64, 8'd8);
    send_packet();

    // length problems: one byte, under the header size, short payload, udp length
    pkt.delete();
    pkt.push_back(8'h60);
    send_packet();
    good_header(16'd11, CMD_RESPONSE);
    void'(pkt.pop_back());
    send_packet();
    good_header(16'd32, CMD_RESPONSE);
    send_packet();
    put_header(16'd32, UDP_PROTO, RIPNG_PORT, RIPNG_PORT, 16'd33, CMD_RESPONSE,
               RIPNG_VERSION, 16'h0);
    add_rand_entry(1'b0);
    send_packet();
    // not udp, with an entry that still goes out
    put_header(16'd32, NH_TCP, RIPNG_PORT, RIPNG_PORT, 16'd32, CMD_RESPONSE,
               RIPNG_VERSION, 16'h0);
    add_entry(128'h2001_0db8_0000_0000_0000_0000_0000_0000, 16'h0, 8'd32, 8'd3);
    send_packet();
    put_header(16'd12, UDP_PROTO, PORT_RIP_V4, RIPNG_PORT, 16'd12, CMD_RESPONSE,
               RIPNG_VERSION, 16'h0);
    send_packet();
    put_header(16'd12, UDP_PROTO, RIPNG_PORT, {RIPNG_PORT[7:0], RIPNG_PORT[15:8]}, 16'd12,
               CMD_RESPONSE, RIPNG_VERSION, 16'h0);
    send_packet();
    // trailing partial entry
    good_header(16'd37, CMD_RESPONSE);
    add_rand_entry(1'b0);
    repeat (5) pkt.push_back(8'($urandom));
    send_packet();
    // command, version and zero field
    good_header(16'd12, CMD_NONE);
    send_packet();
    good_header(16'd12, CMD_UNKNOWN);
    send_packet();
    put_header(16'd12, UDP_PROTO, RIPNG_PORT, RIPNG_PORT, 16'd12, CMD_RESPONSE,
               8'd2, 16'h0);
    send_packet();
    put_header(16'd12, UDP_PROTO, RIPNG_PORT, RIPNG_PORT, 16'd12, CMD_RESPONSE,
               RIPNG_VERSION, 16'h0100);
    send_packet();
    put_header(16'd12, UDP_PROTO, RIPNG_PORT, RIPNG_PORT, 16'd12, CMD_REQUEST,
               RIPNG_VERSION, 16'h0001);
    send_packet();

    // entry errors
    good_header(16'd32, CMD_RESPONSE);
    add_entry(128'hfe80_0000_0000_0000_0000_0000_0000_0001, 16'h0, 8'd1, NEXT_HOP_METRIC);
    send_packet();
    good_header(16'd32, CMD_RESPONSE);
    add_entry(128'hfe80_0000_0000_0000_0000_0000_0000_0001, 16'h0001, 8'd0, NEXT_HOP_METRIC);
    send_packet();
    // a bad entry in the middle stops the ones after it
    good_header(16'd72, CMD_RESPONSE);
    add_rand_entry(1'b0);
    add_entry(128'h2001_0db8_0000_0000_0000_0000_0000_0000, 16'h0, 8'd32, 8'd0);
    add_rand_entry(1'b0);
    send_packet();
    good_header(16'd32, CMD_RESPONSE);
    add_entry(128'h2001_0db8_0000_0000_0000_0000_0000_0000, 16'h0, 8'd32, 8'd17);
    send_packet();
    good_header(16'd32, CMD_RESPONSE);
    add_entry(128'h0, 16'h0, 8'd129, MIN_METRIC);
    send_packet();
    good_header(16'd32, CMD_RESPONSE);
    add_entry(128'h2001_0db8_0000_0001_0000_0000_0000_0001, 16'h0, 8'd64, 8'd2);
    send_packet();
    good_header(16'd32, CMD_RESPONSE);
    add_entry({128{1'b1}}, 16'h0, 8'd127, 8'd2);
    send_packet();
    good_header(16'd32, CMD_RESPONSE);
    add_entry(128'h8000_0000_0000_0000_0000_0000_0000_0000, 16'h0, 8'd0, MIN_METRIC);
    send_packet();

    wait_drained();

    rand_from = bytes_sent;
    while (bytes_sent < rand_from + RANDOM_BYTES) begin
      if (bytes_sent > rand_from + RANDOM_BYTES * 3 / 4) quiet = 1;
      rand_packet();
      send_packet();
      if ($urandom_range(9) == 0) wait_drained();
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending.size()));
    codes = 0;
    foreach (sb.status_seen[i]) if (sb.status_seen[i] != 0) codes++;
    $display("sent %0d bytes; checked %0d packet status results and %0d route entries",
             bytes_sent, sb.packets_out, sb.entries_out);
    $display("%0d of 11 status codes predicted, largest entry count %0d",
             codes, sb.most_entries);
    if (sb.errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/rpv_pkg.sv
rtl/rpv_parser.sv
rtl/rpv_result_fifo.sv
rtl/ripng_packet_validator.sv
verif/testbench.sv
